// ===== src/sha1md_pkg.sv =====
// shared types, constants and helper functions for the sha-1 digest core
// depends on nothing; imported by every module of the block
package sha1md_pkg;

  localparam int unsigned NumChain   = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned NumRounds  = 80;

  // chaining values after reset, element 0 is h0
  localparam logic [NumChain-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'(NumRounds - 1);

  // operations on the block buffer
  typedef enum logic [2:0] {
    SCH_IDLE,
    SCH_BYTE,
    SCH_WORD,
    SCH_PAD,
    SCH_CLEAR,
    SCH_LEN,
    SCH_SHIFT
  } sched_op_e;

  typedef struct packed {
    sched_op_e   op;
    logic [5:0]  pos;
    logic [31:0] data;
    logic [63:0] len;
  } sched_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [6:0] rnd;
  } round_ctrl_t;

  // round function by round group
  function automatic logic [31:0] sha1_f(logic [6:0] rnd, logic [31:0] b,
                                         logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = d ^ (b & (c ^ d));
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (d & (b | c));
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  // round constant by round group
  function automatic logic [31:0] sha1_k(logic [6:0] rnd);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = K_0;
    end else if (rnd < 7'd40) begin
      res = K_1;
    end else if (rnd < 7'd60) begin
      res = K_2;
    end else begin
      res = K_3;
    end
    return res;
  endfunction

endpackage

// ===== src/sha1md_if.sv =====
// valid/ready channel interfaces for message words and digest words
// no dependencies
interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count,
                  output last_word, input ready);
  modport sink (input valid, input data_word, input byte_count,
                input last_word, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_digest_word;

  modport source (output valid, output digest_word, output last_digest_word,
                  input ready);
  modport sink (input valid, input digest_word, input last_digest_word,
                output ready);
endinterface

// ===== src/sha1_message_digest_core.sv =====
// sha-1 digest core: one input transaction at a time, ready stays low while it is absorbed;
// an aligned four-byte word is written whole, a word of n bytes otherwise byte by byte;
// each filled 64-byte block adds a compression (load, 80 rounds, chain update); a last word
// then adds pad, length and one compression, or pad, one compression, clear, length and
// a second compression, then five digest transactions; async active-low reset restores
// chain words and byte count
module sha1_message_digest_core
  import sha1md_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  sha1md_in_if.sink    in_i,
  sha1md_out_if.source out_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ABSORB = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_ROUND  = 4'd3;
  localparam logic [3:0] S_UPDATE = 4'd4;
  localparam logic [3:0] S_PAD    = 4'd5;
  localparam logic [3:0] S_ZERO   = 4'd6;
  localparam logic [3:0] S_LEN    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]                state_q, state_d;
  logic [31:0]               word_q, word_d;
  logic [2:0]                nrem_q, nrem_d;
  logic                      last_q, last_d;
  logic                      fin_q, fin_d;
  logic                      two_q, two_d;
  logic [6:0]                rnd_q, rnd_d;
  logic [2:0]                oidx_q, oidx_d;
  logic [60:0]               count_q, count_d;
  logic [NumChain-1:0][31:0] h_q, h_d;

  logic [5:0]                pos;
  logic [2:0]                nsat;
  logic [31:0]               w;
  logic [NumChain-1:0][31:0] vars;
  sched_ctrl_t               sch;
  round_ctrl_t               rc;

  assign pos  = count_q[5:0];
  assign nsat = (in_i.byte_count > 3'd4) ? 3'd4 : in_i.byte_count;

  sha1md_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sch),
    .w_o    (w)
  );

  sha1md_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (rc),
    .chain_i (h_q),
    .w_i     (w),
    .vars_o  (vars)
  );

  // handshakes
  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = (state_q == S_OUT);
  assign out_o.digest_word      = h_q[oidx_q];
  assign out_o.last_digest_word = (oidx_q == 3'd4);

  // sequencer
  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    nrem_d  = nrem_q;
    last_d  = last_q;
    fin_d   = fin_q;
    two_d   = two_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    count_d = count_q;
    h_d     = h_q;

    sch      = '0;
    sch.op   = SCH_IDLE;
    sch.pos  = pos;
    sch.data = word_q;
    sch.len  = {count_q, 3'b000};
    rc       = '0;
    rc.rnd   = rnd_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          word_d  = in_i.data_word;
          nrem_d  = nsat;
          last_d  = in_i.last_word;
          state_d = S_ABSORB;
        end
      end
      S_ABSORB: begin
        if (nrem_q == 3'd0) begin
          state_d = last_q ? S_PAD : S_IDLE;
        end else if (nrem_q == 3'd4 && pos[1:0] == 2'd0) begin
          // aligned full word in one write
          sch.op  = SCH_WORD;
          count_d = count_q + 61'd4;
          nrem_d  = 3'd0;
          if (pos[5:2] == 4'd15) begin
            state_d = S_LOAD;
          end
        end else begin
          sch.op  = SCH_BYTE;
          count_d = count_q + 61'd1;
          nrem_d  = nrem_q - 3'd1;
          word_d  = {word_q[23:0], 8'h00};
          if (pos == 6'd63) begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        rc.load = 1'b1;
        rnd_d   = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        rc.step = 1'b1;
        sch.op  = SCH_SHIFT;
        rnd_d   = rnd_q + 7'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        for (int i = 0; i < NumChain; i++) begin
          h_d[i] = h_q[i] + vars[i];
        end
        if (!fin_q) begin
          state_d = S_ABSORB;
        end else if (two_q) begin
          two_d   = 1'b0;
          state_d = S_ZERO;
        end else begin
          oidx_d  = '0;
          state_d = S_OUT;
        end
      end
      S_PAD: begin
        sch.op = SCH_PAD;
        fin_d  = 1'b1;
        if (pos >= 6'd56) begin
          two_d   = 1'b1;
          state_d = S_LOAD;
        end else begin
          state_d = S_LEN;
        end
      end
      S_ZERO: begin
        sch.op  = SCH_CLEAR;
        state_d = S_LEN;
      end
      S_LEN: begin
        sch.op  = SCH_LEN;
        state_d = S_LOAD;
      end
      S_OUT: begin
        if (out_o.ready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd4) begin
            h_d     = H_INIT;
            count_d = '0;
            fin_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nrem_q  <= '0;
      last_q  <= 1'b0;
      fin_q   <= 1'b0;
      two_q   <= 1'b0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      count_q <= '0;
      h_q     <= H_INIT;
    end else begin
      state_q <= state_d;
      nrem_q  <= nrem_d;
      last_q  <= last_d;
      fin_q   <= fin_d;
      two_q   <= two_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      count_q <= count_d;
      h_q     <= h_d;
    end
  end

  // pending input word
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ===== src/sha1md_sched.sv =====
// block buffer and message schedule: byte/word fill, padding, length, and
// a 16-entry shift window producing w[t] one per round; uses sha1md_pkg
module sha1md_sched
  import sha1md_pkg::*;
(
  input  logic        clk_i,
  input  sched_ctrl_t ctrl_i,
  output logic [31:0] w_o
);

  logic [BlockWords-1:0][31:0] buf_q;
  logic [BlockWords-1:0][31:0] padded;
  logic [31:0]                 w_next;

  // padded view: 0x80 at the fill position, zeros after it
  always_comb begin
    padded = buf_q;
    for (int i = 0; i < BlockWords; i++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(i * 4 + b) == ctrl_i.pos) begin
          padded[i][(3 - b) * 8 +: 8] = PAD_BYTE;
        end else if (6'(i * 4 + b) > ctrl_i.pos) begin
          padded[i][(3 - b) * 8 +: 8] = 8'h00;
        end
      end
    end
  end

  // next schedule word from the window taps
  always_comb begin
    w_next = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];
    w_next = {w_next[30:0], w_next[31]};
  end

  assign w_o = buf_q[0];

  // buffer update
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      SCH_BYTE: begin
        buf_q[ctrl_i.pos[5:2]][(2'd3 - ctrl_i.pos[1:0]) * 8 +: 8] <= ctrl_i.data[31:24];
      end
      SCH_WORD: begin
        buf_q[ctrl_i.pos[5:2]] <= ctrl_i.data;
      end
      SCH_PAD: begin
        buf_q <= padded;
      end
      SCH_CLEAR: begin
        buf_q <= '0;
      end
      SCH_LEN: begin
        buf_q[14] <= ctrl_i.len[63:32];
        buf_q[15] <= ctrl_i.len[31:0];
      end
      SCH_SHIFT: begin
        for (int j = 0; j < BlockWords - 1; j++) begin
          buf_q[j] <= buf_q[j + 1];
        end
        buf_q[BlockWords - 1] <= w_next;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sha1md_round.sv =====
// shared sha-1 round unit: working variables a..e, one round per step
// uses sha1md_pkg
module sha1md_round
  import sha1md_pkg::*;
(
  input  logic                       clk_i,
  input  round_ctrl_t                ctrl_i,
  input  logic [NumChain-1:0][31:0]  chain_i,
  input  logic [31:0]                w_i,
  output logic [NumChain-1:0][31:0]  vars_o
);

  // element 0 is a, element 4 is e
  logic [NumChain-1:0][31:0] vars_q;
  logic [31:0]               tmp;

  // one round of the compression function
  always_comb begin
    tmp = {vars_q[0][26:0], vars_q[0][31:27]}
        + sha1_f(ctrl_i.rnd, vars_q[1], vars_q[2], vars_q[3])
        + vars_q[4] + sha1_k(ctrl_i.rnd) + w_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      vars_q <= chain_i;
    end else if (ctrl_i.step) begin
      vars_q[4] <= vars_q[3];
      vars_q[3] <= vars_q[2];
      vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
      vars_q[1] <= vars_q[0];
      vars_q[0] <= tmp;
    end
  end

  assign vars_o = vars_q;

endmodule

// ===== tb/sha1md_digest_checker.sv =====
// digest checker: watches the message and digest channels, predicts sha-1
// digests from the accepted message words and compares every digest word
// depends on sha1md_pkg and the channel interfaces in sha1md_if.sv
module sha1md_digest_checker
  import sha1md_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  sha1md_in_if  msg_mon,
  sha1md_out_if dig_mon,
  output int    fail_count_o,
  output int    pending_o,
  output int    digest_words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic        fin;
  } digest_exp_t;

  // predicted engine state
  logic [31:0] chain_q [NumChain];
  logic [31:0] blk_q [BlockWords];
  logic [60:0] nbytes_q;

  digest_exp_t digest_expected_q [$];
  int          fail_cnt;
  int          checked_cnt;

  // back to the initial chaining values and an empty message
  function automatic void restart_message();
    int i;
    for (i = 0; i < NumChain; i++) chain_q[i] = H_INIT[i];
    nbytes_q = '0;
  endfunction

  // one 80-round compression of the block buffer into the chain
  function automatic void fold_block();
    logic [31:0] sched [NumRounds];
    logic [31:0] a, b, c, d, e, t, fv, kv;
    int r;
    for (r = 0; r < BlockWords; r++) sched[r] = blk_q[r];
    for (r = BlockWords; r < NumRounds; r++) begin
      t = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
      sched[r] = {t[30:0], t[31]};
    end
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (r = 0; r < NumRounds; r++) begin
      if (r < 20) begin
        fv = d ^ (b & (c ^ d));
        kv = K_0;
      end else if (r < 40) begin
        fv = b ^ c ^ d;
        kv = K_1;
      end else if (r < 60) begin
        fv = (b & c) | (d & (b | c));
        kv = K_2;
      end else begin
        fv = b ^ c ^ d;
        kv = K_3;
      end
      t = {a[26:0], a[31:27]} + fv + e + kv + sched[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
    chain_q[4] = chain_q[4] + e;
  endfunction

  // write one byte at a block position, big-endian within the word
  function automatic void place_byte(logic [5:0] pos, logic [7:0] val);
    int lane;
    lane = 3 - int'(pos[1:0]);
    blk_q[pos[5:2]][lane*8 +: 8] = val;
  endfunction

  // message byte into the block, compress when the block fills
  function automatic void append_byte(logic [7:0] val);
    logic [5:0] pos;
    pos = nbytes_q[5:0];
    place_byte(pos, val);
    nbytes_q = nbytes_q + 61'd1;
    if (pos == 6'd63) fold_block();
  endfunction

  // padding, bit length and the final compression (two if no room)
  function automatic void pad_and_finish();
    logic [5:0]  pos;
    logic [63:0] bit_len;
    int i;
    pos = nbytes_q[5:0];
    bit_len = {nbytes_q, 3'b000};
    place_byte(pos, PAD_BYTE);
    for (i = int'(pos) + 1; i < 64; i++) place_byte(6'(i), 8'h00);
    if (pos >= 6'd56) begin
      fold_block();
      for (i = 0; i < BlockWords; i++) blk_q[i] = '0;
    end
    blk_q[14] = bit_len[63:32];
    blk_q[15] = bit_len[31:0];
    fold_block();
  endfunction

  // one accepted message word; five digest words expected on the last one
  function automatic void take_message_word(logic [31:0] data, logic [2:0] cnt,
                                            logic fin);
    int n;
    int i;
    digest_exp_t exp_word;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (i = 0; i < n; i++) append_byte(data[31-8*i -: 8]);
    if (fin) begin
      pad_and_finish();
      for (i = 0; i < NumChain; i++) begin
        exp_word.word = chain_q[i];
        exp_word.fin  = (i == NumChain - 1);
        digest_expected_q.push_back(exp_word);
      end
      restart_message();
    end
  endfunction

  // compare one digest transaction against the oldest expectation
  function automatic void check_digest_word(logic [31:0] word, logic fin);
    digest_exp_t exp_word;
    if (digest_expected_q.size() == 0) begin
      $error("unexpected digest transaction: digest_word %08h last_digest_word %0b",
             word, fin);
      fail_cnt++;
    end else begin
      exp_word = digest_expected_q.pop_front();
      checked_cnt++;
      if (word !== exp_word.word) begin
        $error("digest_word mismatch: expected %08h, actual %08h", exp_word.word, word);
        fail_cnt++;
      end
      if (fin !== exp_word.fin) begin
        $error("last_digest_word mismatch: expected %0b, actual %0b", exp_word.fin, fin);
        fail_cnt++;
      end
    end
  endfunction

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      for (int i = 0; i < BlockWords; i++) blk_q[i] = '0;
      digest_expected_q.delete();
      fail_cnt = 0;
      checked_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      digest_words_o <= 0;
    end else begin
      if (msg_mon.valid && msg_mon.ready) begin
        take_message_word(msg_mon.data_word, msg_mon.byte_count, msg_mon.last_word);
      end
      if (dig_mon.valid && dig_mon.ready) begin
        check_digest_word(dig_mon.digest_word, dig_mon.last_digest_word);
      end
      fail_count_o <= fail_cnt;
      pending_o <= digest_expected_q.size();
      digest_words_o <= checked_cnt;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the sha-1 digest core testbench: clock, reset, message stimulus,
// digest back-pressure and the verdict
// depends on sha1md_pkg, sha1md_if.sv, the core and sha1md_digest_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 110;
  localparam int DrainCycles = 200;

  logic clk;
  logic rst_n;

  int words_sent;
  int messages_sent;
  int src_calm;
  int snk_calm;

  int chk_fails;
  int chk_pending;
  int chk_digest_words;

  sha1md_in_if  msg_if ();
  sha1md_out_if dig_if ();

  sha1_message_digest_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (msg_if),
    .out_o  (dig_if)
  );

  sha1md_digest_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .msg_mon        (msg_if),
    .dig_mon        (dig_if),
    .fail_count_o   (chk_fails),
    .pending_o      (chk_pending),
    .digest_words_o (chk_digest_words)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles before the next transaction, with occasional calm stretches
  function automatic int next_gap(ref int calm);
    int gap;
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    end
    return gap;
  endfunction

  // one message word transaction, held until accepted
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                           input logic fin);
    int gap;
    gap = next_gap(src_calm);
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_if.valid      <= 1'b1;
    msg_if.data_word  <= data;
    msg_if.byte_count <= cnt;
    msg_if.last_word  <= fin;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    words_sent++;
    if (fin) messages_sent++;
  endtask

  // random message: full words, some short or oversized words when noisy
  task automatic send_message(input int body_words, input bit noisy);
    logic [2:0] cnt;
    int i;
    for (i = 0; i < body_words; i++) begin
      cnt = 3'd4;
      if (noisy && $urandom_range(0, 3) == 0) cnt = 3'($urandom_range(0, 7));
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // digest side back-pressure
  initial begin
    int gap;
    dig_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = next_gap(snk_calm);
      if (gap > 0) begin
        dig_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dig_if.ready <= 1'b1;
      @(posedge clk);
      while (!dig_if.valid) @(posedge clk);
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int body;
    int pick;
    words_sent    = 0;
    messages_sent = 0;
    src_calm      = 0;
    snk_calm      = 0;
    msg_if.valid      <= 1'b0;
    msg_if.data_word  <= '0;
    msg_if.byte_count <= '0;
    msg_if.last_word  <= 1'b0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message
    send_word(32'h0000_0000, 3'd0, 1'b1);
    // "abc" with junk below the valid bytes
    send_word(32'h6162_63FF, 3'd3, 1'b1);
    // 56 bytes of ones: length does not fit, two final compressions
    repeat (14) send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    // oversized counts saturate, short words inside the message
    send_word(32'hA5A5_A5A5, 3'd7, 1'b0);
    send_word(32'h1234_5678, 3'd1, 1'b0);
    send_word(32'hDEAD_BEEF, 3'd5, 1'b0);
    send_word(32'hCAFE_F00D, 3'd6, 1'b1);

    // random messages, mostly short, some crossing one or two blocks
    while (words_sent < RandomWords + 21) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        body = $urandom_range(0, 6);
      end else if (pick < 9) begin
        body = $urandom_range(7, 15);
      end else begin
        body = $urandom_range(16, 33);
      end
      send_message(body, $urandom_range(0, 3) == 0);
    end
    msg_if.valid <= 1'b0;

    // let the checker register the last transaction, then drain outstanding digests
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d message words in %0d messages", words_sent, messages_sent);
    $display("%0d digest words compared, %0d mismatches", chk_digest_words, chk_fails);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sha1md_pkg.sv
src/sha1md_if.sv
src/sha1md_sched.sv
src/sha1md_round.sv
src/sha1_message_digest_core.sv
tb/sha1md_digest_checker.sv
tb/testbench.sv
